@@ src/pspu_pkg.sv @@
package pspu_pkg;

	localparam int unsigned BYTE_W = 8;
	localparam int unsigned WORD_BYTES = 4;
	localparam int unsigned WORD_W = BYTE_W * WORD_BYTES;
	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned CFG_DATA_W = 6;
	localparam logic [BYTE_W-1:0] BYTE_MASK = 8'hFF;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_BIG_ENDIAN      = 3'd0,
		CFG_IS_SIGNED       = 3'd1,
		CFG_PAD_AT_LSB      = 3'd2,
		CFG_CONTAINER_BYTES = 3'd3,
		CFG_SAMPLE_BITS     = 3'd4
	} cfg_idx_t;

	// effective settings after clamping, as seen by the datapath
	typedef struct packed {
		logic       big_endian;
		logic       is_signed;
		logic       pad_at_lsb;
		logic [2:0] nbytes;
		logic [5:0] bits;
	} cfg_t;

endpackage

@@ src/pspu_cfg.sv @@
module pspu_cfg (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_we,
	input  logic [pspu_pkg::CFG_IDX_W-1:0]        cfg_idx,
	input  logic [pspu_pkg::CFG_DATA_W-1:0]       cfg_wdata,
	output pspu_pkg::cfg_t                        cfg
);

	logic       big_endian_q;
	logic       is_signed_q;
	logic       pad_at_lsb_q;
	logic [2:0] container_bytes_q;
	logic [5:0] sample_bits_q;

	logic [2:0] nbytes;
	logic [5:0] cont_bits;
	logic [5:0] bits;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			big_endian_q      <= 1'b0;
			is_signed_q       <= 1'b1;
			pad_at_lsb_q      <= 1'b0;
			container_bytes_q <= 3'd2;
			sample_bits_q     <= 6'd16;
		end else if (cfg_we) begin
			case (cfg_idx)
				pspu_pkg::CFG_BIG_ENDIAN:      big_endian_q      <= cfg_wdata[0];
				pspu_pkg::CFG_IS_SIGNED:       is_signed_q       <= cfg_wdata[0];
				pspu_pkg::CFG_PAD_AT_LSB:      pad_at_lsb_q      <= cfg_wdata[0];
				pspu_pkg::CFG_CONTAINER_BYTES: container_bytes_q <= cfg_wdata[2:0];
				pspu_pkg::CFG_SAMPLE_BITS:     sample_bits_q     <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// clamp container to 1..4 bytes and bit count to 1..8*bytes
	always_comb begin
		if (container_bytes_q == 3'd0) begin
			nbytes = 3'd1;
		end else if (container_bytes_q > 3'd4) begin
			nbytes = 3'd4;
		end else begin
			nbytes = container_bytes_q;
		end
		cont_bits = {nbytes, 3'b000};
		if (sample_bits_q == 6'd0) begin
			bits = 6'd1;
		end else if (sample_bits_q > cont_bits) begin
			bits = cont_bits;
		end else begin
			bits = sample_bits_q;
		end
		cfg.big_endian = big_endian_q;
		cfg.is_signed  = is_signed_q;
		cfg.pad_at_lsb = pad_at_lsb_q;
		cfg.nbytes     = nbytes;
		cfg.bits       = bits;
	end

endmodule

@@ src/pspu_conv.sv @@
module pspu_conv (
	input  pspu_pkg::cfg_t                    cfg,
	input  logic                              mode,
	input  logic [pspu_pkg::WORD_W-1:0]       raw_in,
	input  logic [pspu_pkg::WORD_W-1:0]       sample_in,
	output logic [pspu_pkg::WORD_W-1:0]       raw_out,
	output logic [pspu_pkg::WORD_W-1:0]       sample_out
);

	localparam logic [pspu_pkg::WORD_W-1:0] ONES = '1;

	// stream order <-> native value, bytes at or above nbytes dropped
	function automatic logic [pspu_pkg::WORD_W-1:0] reorder(
		input logic [pspu_pkg::WORD_W-1:0] v,
		input logic [2:0]                  nb,
		input logic                        be
	);
		logic [pspu_pkg::WORD_W-1:0] r;
		logic [2:0]                  src;
		r = '0;
		for (int p = 0; p < pspu_pkg::WORD_BYTES; p++) begin
			src = be ? (nb - 3'd1 - 3'(p)) : 3'(p);
			if (3'(p) < nb) begin
				r[p*pspu_pkg::BYTE_W +: pspu_pkg::BYTE_W] =
					v[src[1:0]*pspu_pkg::BYTE_W +: pspu_pkg::BYTE_W] & pspu_pkg::BYTE_MASK;
			end
		end
		return r;
	endfunction

	logic [5:0]                  cont_bits;
	logic [5:0]                  pad_sh;
	logic [5:0]                  top_bit;
	logic [pspu_pkg::WORD_W-1:0] bit_mask;
	logic [pspu_pkg::WORD_W-1:0] cont_mask;
	logic [pspu_pkg::WORD_W-1:0] offset;
	logic [pspu_pkg::WORD_W-1:0] un_native;
	logic [pspu_pkg::WORD_W-1:0] un_field;
	logic [pspu_pkg::WORD_W-1:0] un_value;
	logic [pspu_pkg::WORD_W-1:0] pk_value;
	logic [pspu_pkg::WORD_W-1:0] pk_native;

	always_comb begin
		cont_bits = {cfg.nbytes, 3'b000};
		pad_sh    = cont_bits - cfg.bits;
		top_bit   = cfg.bits - 6'd1;
		// a shift by the full width gives zero, so 32 bits yields an all-ones mask
		bit_mask  = ~(ONES << cfg.bits);
		cont_mask = ~(ONES << cont_bits);
		offset    = {{(pspu_pkg::WORD_W-1){1'b0}}, 1'b1} << top_bit;

		un_native = reorder(raw_in, cfg.nbytes, cfg.big_endian);
		un_field  = (cfg.pad_at_lsb ? (un_native >> pad_sh) : un_native) & bit_mask;
		if (cfg.is_signed) begin
			un_value = un_field[top_bit[4:0]] ? (un_field | ~bit_mask) : un_field;
		end else begin
			un_value = un_field - offset;
		end

		pk_value  = cfg.is_signed ? sample_in : (sample_in + offset);
		pk_native = (cfg.pad_at_lsb ? (pk_value << pad_sh) : pk_value) & cont_mask;

		if (mode) begin
			raw_out    = reorder(pk_native, cfg.nbytes, cfg.big_endian);
			sample_out = '0;
		end else begin
			raw_out    = '0;
			sample_out = un_value;
		end
	end

endmodule

@@ src/pcm_sample_pack_unpack_top.sv @@
// done follows a taken request through the input stage register, then the output stage register
// throughput: one request every cycle, busy stays low
// request registered on entry, converted in one pass, result registered on exit
// done is high for one cycle per request; the receiver cannot stall
// reset clears the pipeline valid flags and loads the default format settings
module pcm_sample_pack_unpack_top (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic                                mode,
	input  logic [31:0]                         raw_in,
	input  logic signed [31:0]                  sample_in,
	output logic                                done,
	output logic [31:0]                         raw_out,
	output logic signed [31:0]                  sample_out,
	input  logic                                cfg_we,
	input  logic [pspu_pkg::CFG_IDX_W-1:0]      cfg_idx,
	input  logic [pspu_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

	pspu_pkg::cfg_t cfg;

	logic        valid_s1;
	logic        mode_s1;
	logic [31:0] raw_s1;
	logic [31:0] sample_s1;

	logic        valid_s2;
	logic        mode_s2;
	logic [31:0] raw_s2;
	logic [31:0] sample_s2;

	logic [31:0] conv_raw;
	logic [31:0] conv_sample;

	assign busy = 1'b0;

	pspu_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			mode_s1   <= mode;
			raw_s1    <= raw_in;
			sample_s1 <= $unsigned(sample_in);
		end
		if (valid_s1) begin
			mode_s2   <= mode_s1;
			raw_s2    <= conv_raw;
			sample_s2 <= conv_sample;
		end
	end

	pspu_conv u_conv (
		.cfg        (cfg),
		.mode       (mode_s1),
		.raw_in     (raw_s1),
		.sample_in  (sample_s1),
		.raw_out    (conv_raw),
		.sample_out (conv_sample)
	);

	assign done       = valid_s2;
	assign raw_out    = raw_s2;
	assign sample_out = $signed(sample_s2);

	a_accept_enters: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> valid_s1)
		else $error("accepted request did not enter the input stage");

	a_stage_to_done: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |=> done)
		else $error("request in the input stage produced no result");

	a_done_has_source: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(valid_s1))
		else $error("result strobe without a request behind it");

	a_unpack_raw_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !mode_s2) |-> (raw_out == 32'd0))
		else $error("unpack result carries a nonzero raw_out");

	a_pack_sample_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && mode_s2) |-> (sample_out == 32'sd0))
		else $error("pack result carries a nonzero sample_out");

endmodule
